>>> sv/bsi_pkg.sv
// shared types and constants for the blade section interpolator
// used by bsi_front, bsi_back and blade_section_interpolator
package bsi_pkg;

	localparam int MAX_SECTIONS_DEF = 64;
	localparam int FRAC_BITS_DEF = 16;

	// pi/180 in Q0.32
	localparam logic [31:0] DEG_TO_RAD_Q32 = 32'd74961321;

	localparam logic [1:0] REG_ADIMENSIONAL = 2'd0;
	localparam logic [1:0] REG_MAX_RADIUS = 2'd1;
	localparam logic [1:0] REG_SECTION_COUNT = 2'd2;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic        kind;
		logic        wr_ok;
		logic [5:0]  section_index;
		logic [31:0] radius;
		logic [31:0] chord;
		logic [31:0] twist_deg;
		logic [31:0] sweep_deg;
	} item_t;

	typedef struct packed {
		logic        adimensional;
		logic [31:0] max_radius;
		logic [6:0]  section_count;
	} cfg_t;

endpackage

>>> sv/bsi_front.sv
// front end: accepts items, flags loads that fall outside the table,
// and holds them in a two-word queue; depends on bsi_pkg
module bsi_front #(
	parameter int MAX_SECTIONS = bsi_pkg::MAX_SECTIONS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  logic           kind,
	input  logic [5:0]     section_index,
	input  logic [31:0]    radius,
	input  logic [31:0]    chord,
	input  logic [31:0]    twist_deg,
	input  logic [31:0]    sweep_deg,
	output logic           q_valid,
	output bsi_pkg::item_t q_item,
	input  logic           q_pop
);
	import bsi_pkg::*;

	item_t      buf_q [2];
	item_t      new_item;
	logic       wp_q, rp_q;
	logic [1:0] count_q;
	logic       push;
	logic [31:0] idx32;

	assign idx32 = {26'b0, section_index};

	always_comb begin
		new_item.kind = kind;
		new_item.wr_ok = (idx32 < 32'(MAX_SECTIONS));
		new_item.section_index = section_index;
		new_item.radius = radius;
		new_item.chord = chord;
		new_item.twist_deg = twist_deg;
		new_item.sweep_deg = sweep_deg;
	end

	assign item_stall = (count_q == 2'd2);
	assign push = item_valid && !item_stall;
	assign q_valid = (count_q != 2'd0);
	assign q_item = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			case ({push, q_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count overflow");
	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> item_stall) else $error("full queue not stalling");

endmodule

>>> sv/bsi_back.sv
// back end: section table memory, shared divider and multiplier, and the
// sequencer for loads and queries; depends on bsi_pkg
module bsi_back #(
	parameter int MAX_SECTIONS = bsi_pkg::MAX_SECTIONS_DEF,
	parameter int FRAC_BITS = bsi_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  bsi_pkg::item_t q_item,
	output logic           q_pop,
	input  bsi_pkg::cfg_t  cfg,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [31:0]    chord_out,
	output logic [31:0]    twist_out,
	output logic [31:0]    sweep_out,
	output logic           in_range
);
	import bsi_pkg::*;

	localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int DW = 32 + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam logic [DW-1:0] T_ONE = DW'(1) << FRAC_BITS;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LMT, ST_LMS, ST_LWR, ST_ADIV, ST_SCAN, ST_SCANW, ST_CHK,
		ST_TDIV, ST_RDLO, ST_RDHI, ST_CAP, ST_LMUL, ST_LADD, ST_DONE
	} state_t;

	state_t state_q;
	item_t  item_q;

	// table memory
	logic [31:0] rad_mem [MAX_SECTIONS];
	logic [31:0] chd_mem [MAX_SECTIONS];
	logic [31:0] tw_mem [MAX_SECTIONS];
	logic [31:0] sw_mem [MAX_SECTIONS];
	logic [31:0] rd_rad_q, rd_chd_q, rd_tw_q, rd_sw_q;
	logic [AW-1:0] raddr, waddr;
	logic        mem_we;
	logic [31:0] idx32;

	// divider
	logic [DW-1:0] shreg_q, shreg_nx;
	logic [31:0]   rem_q, divisor_q;
	logic [32:0]   rem_sh, rem_nx;
	logic          div_ge;
	logic [CW-1:0] dcnt_q;
	logic          div_last;

	// multiplier
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] prod_q;

	// query context
	logic [31:0]   r_q, r0_q, rlast_q, rlo_q, rhi_q;
	logic [AW-1:0] scan_i_q, lo_q, hi_q, cmp_k_q, last_idx;
	logic          cmp_v_q, have_hi_q;
	logic [FRAC_BITS:0] t_q;
	logic [31:0]   a_chd_q, a_tw_q, a_sw_q, b_chd_q, b_tw_q, b_sw_q;
	logic [1:0]    fld_q;
	logic          neg_q;
	logic [31:0]   a_sel_q;
	logic [31:0]   twist_rad_q;
	logic [31:0]   res_chd_q, res_tw_q, res_sw_q;
	logic          res_rng_q;
	logic          result_valid_q;
	logic [31:0]   out_chd_q, out_tw_q, out_sw_q;
	logic          out_rng_q;

	logic [31:0] sc32, last32;
	logic [31:0] tw_mag, sw_mag, rad_cur;
	logic [63:0] rad_round;
	logic [32:0] fa, fb;
	logic [33:0] diff, diff_mag;
	logic [31:0] fa32;
	logic [64:0] step_sum;
	logic [64:0] step_full;
	logic [31:0] lerp_res;
	logic [DW-1:0] quot_t;

	// clamp of section_count to 1..MAX_SECTIONS, as last index
	assign sc32 = {25'b0, cfg.section_count};
	assign last32 = (sc32 == 32'd0) ? 32'd0 :
		((sc32 > 32'(MAX_SECTIONS)) ? 32'(MAX_SECTIONS - 1) : sc32 - 32'd1);
	assign last_idx = last32[AW-1:0];

	assign idx32 = {26'b0, item_q.section_index};
	assign waddr = idx32[AW-1:0];

	assign tw_mag = item_q.twist_deg[31] ? (32'd0 - item_q.twist_deg) : item_q.twist_deg;
	assign sw_mag = item_q.sweep_deg[31] ? (32'd0 - item_q.sweep_deg) : item_q.sweep_deg;
	// round half away from zero, sign of the angle being finished
	assign rad_round = prod_q[63:0] + 64'h8000_0000;

	always_comb begin
		if (state_q == ST_LMS) begin
			rad_cur = item_q.twist_deg[31] ? (32'd0 - rad_round[63:32]) : rad_round[63:32];
		end else begin
			rad_cur = item_q.sweep_deg[31] ? (32'd0 - rad_round[63:32]) : rad_round[63:32];
		end
	end

	// divider step, one quotient bit a cycle
	assign rem_sh = {rem_q, shreg_q[DW-1]};
	assign div_ge = (rem_sh >= {1'b0, divisor_q});
	assign rem_nx = div_ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
	assign shreg_nx = {shreg_q[DW-2:0], div_ge};
	assign div_last = (dcnt_q == CW'(DW - 1));
	assign quot_t = shreg_nx;

	// lerp operands of the current field
	always_comb begin
		case (fld_q)
			2'd0: begin
				fa = {1'b0, a_chd_q};
				fb = {1'b0, b_chd_q};
			end
			2'd1: begin
				fa = {a_tw_q[31], a_tw_q};
				fb = {b_tw_q[31], b_tw_q};
			end
			default: begin
				fa = {a_sw_q[31], a_sw_q};
				fb = {b_sw_q[31], b_sw_q};
			end
		endcase
	end
	assign fa32 = fa[31:0];
	assign diff = {fb[32], fb} - {fa[32], fa};
	assign diff_mag = diff[33] ? (34'd0 - diff) : diff;

	always_comb begin
		case (state_q)
			ST_LMT: begin
				mul_a = {1'b0, tw_mag};
				mul_b = DEG_TO_RAD_Q32;
			end
			ST_LMS: begin
				mul_a = {1'b0, sw_mag};
				mul_b = DEG_TO_RAD_Q32;
			end
			default: begin
				mul_a = diff_mag[32:0];
				mul_b = {{(31 - FRAC_BITS){1'b0}}, t_q};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 65'(mul_a * mul_b);
	end

	assign step_sum = prod_q + (65'd1 << (FRAC_BITS - 1));
	assign step_full = step_sum >> FRAC_BITS;
	assign lerp_res = neg_q ? (a_sel_q - step_full[31:0]) : (a_sel_q + step_full[31:0]);

	always_comb begin
		case (state_q)
			ST_SCAN: raddr = scan_i_q;
			ST_RDLO: raddr = lo_q;
			ST_RDHI: raddr = hi_q;
			default: raddr = '0;
		endcase
	end

	assign mem_we = (state_q == ST_LWR) && item_q.wr_ok;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			rad_mem[waddr] <= item_q.radius;
			chd_mem[waddr] <= item_q.chord;
			tw_mem[waddr] <= twist_rad_q;
			sw_mem[waddr] <= rad_cur;
		end
		rd_rad_q <= rad_mem[raddr];
		rd_chd_q <= chd_mem[raddr];
		rd_tw_q <= tw_mem[raddr];
		rd_sw_q <= sw_mem[raddr];
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
			cmp_v_q <= 1'b0;
		end else begin
			// the done step reloads the output word itself
			if (state_q != ST_DONE && result_valid_q && !result_stall)
				result_valid_q <= 1'b0;
			cmp_v_q <= (state_q == ST_SCAN);

			if (state_q == ST_ADIV || state_q == ST_TDIV) begin
				rem_q <= rem_nx[31:0];
				shreg_q <= shreg_nx;
				dcnt_q <= dcnt_q + CW'(1);
			end

			// scan compare, one entry a cycle, on the registered table read
			if (cmp_v_q) begin
				if (rd_rad_q <= r_q) begin
					lo_q <= cmp_k_q;
					rlo_q <= rd_rad_q;
				end
				if (!have_hi_q && rd_rad_q >= r_q) begin
					hi_q <= cmp_k_q;
					rhi_q <= rd_rad_q;
					have_hi_q <= 1'b1;
				end
				if (cmp_k_q == '0) r0_q <= rd_rad_q;
				if (cmp_k_q == last_idx) rlast_q <= rd_rad_q;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						r_q <= q_item.radius;
						scan_i_q <= '0;
						have_hi_q <= 1'b0;
						lo_q <= '0;
						hi_q <= '0;
						rlo_q <= '0;
						rhi_q <= '0;
						if (q_item.kind == KIND_LOAD) begin
							state_q <= ST_LMT;
						end else if (cfg.adimensional && cfg.max_radius != 32'd0) begin
							shreg_q <= {q_item.radius, {FRAC_BITS{1'b0}}};
							rem_q <= '0;
							divisor_q <= cfg.max_radius;
							dcnt_q <= '0;
							state_q <= ST_ADIV;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_LMT: state_q <= ST_LMS;
				ST_LMS: begin
					twist_rad_q <= rad_cur;
					state_q <= ST_LWR;
				end
				ST_LWR: state_q <= ST_IDLE;
				ST_ADIV: begin
					if (div_last) begin
						r_q <= (|shreg_nx[DW-1:32]) ? 32'hFFFF_FFFF : shreg_nx[31:0];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_k_q <= scan_i_q;
					if (scan_i_q == last_idx) begin
						state_q <= ST_SCANW;
					end else begin
						scan_i_q <= scan_i_q + AW'(1);
					end
				end
				ST_SCANW: state_q <= ST_CHK;
				ST_CHK: begin
					if (r_q < r0_q || r_q > rlast_q) begin
						res_chd_q <= '0;
						res_tw_q <= '0;
						res_sw_q <= '0;
						res_rng_q <= 1'b0;
						state_q <= ST_DONE;
					end else if (rhi_q > rlo_q) begin
						shreg_q <= {r_q - rlo_q, {FRAC_BITS{1'b0}}};
						rem_q <= '0;
						divisor_q <= rhi_q - rlo_q;
						dcnt_q <= '0;
						state_q <= ST_TDIV;
					end else begin
						// zero span or an unsorted pair: stay at the lower entry
						t_q <= '0;
						state_q <= ST_RDLO;
					end
				end
				ST_TDIV: begin
					if (div_last) begin
						t_q <= (quot_t > T_ONE) ? T_ONE[FRAC_BITS:0] : quot_t[FRAC_BITS:0];
						state_q <= ST_RDLO;
					end
				end
				ST_RDLO: state_q <= ST_RDHI;
				ST_RDHI: begin
					a_chd_q <= rd_chd_q;
					a_tw_q <= rd_tw_q;
					a_sw_q <= rd_sw_q;
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					b_chd_q <= rd_chd_q;
					b_tw_q <= rd_tw_q;
					b_sw_q <= rd_sw_q;
					fld_q <= 2'd0;
					res_rng_q <= 1'b1;
					state_q <= ST_LMUL;
				end
				ST_LMUL: begin
					neg_q <= diff[33];
					a_sel_q <= fa32;
					state_q <= ST_LADD;
				end
				ST_LADD: begin
					case (fld_q)
						2'd0: res_chd_q <= lerp_res;
						2'd1: res_tw_q <= lerp_res;
						default: res_sw_q <= lerp_res;
					endcase
					if (fld_q == 2'd2) begin
						state_q <= ST_DONE;
					end else begin
						fld_q <= fld_q + 2'd1;
						state_q <= ST_LMUL;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || !result_stall) begin
						out_chd_q <= res_chd_q;
						out_tw_q <= res_tw_q;
						out_sw_q <= res_sw_q;
						out_rng_q <= res_rng_q;
						result_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign chord_out = out_chd_q;
	assign twist_out = out_tw_q;
	assign sweep_out = out_sw_q;
	assign in_range = out_rng_q;

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done");
	a_zero_outside: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !out_rng_q) |->
		(out_chd_q == 32'd0 && out_tw_q == 32'd0 && out_sw_q == 32'd0))
		else $error("nonzero result outside range");
	a_pop_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_IDLE))
		else $error("queue popped while busy");

endmodule

>>> sv/blade_section_interpolator.sv
// blade section interpolator top level: configuration registers,
// front queue and back sequencer; depends on bsi_pkg, bsi_front, bsi_back
//
// item channel (item_valid/item_stall): kind 0 loads one section at
// section_index, converting twist and sweep from degrees to radians; kind 1
// queries at radius. A two-word queue in front lets items be taken while the
// back end works and while a result waits.
// result channel (result_valid/result_stall): one word per query, none per
// load. The output register holds while result_stall is high; the back end
// then waits in its done step and the queue fills and stalls the input.
// config channel (cfg_valid/cfg_ready, always ready): index 0 adimensional,
// 1 max_radius, 2 section_count; other indexes are ignored.
// a load holds the back end through its LMT, LMS and LWR steps. A query's
// time from acceptance to result is set by the table scan of one entry a
// cycle over the n sections in use and by the bit-serial divider (used for
// the max_radius scaling and again for the segment fraction);
// without scaling the first divide is skipped, and a query outside the
// table or on a zero span skips the second.
// reset empties the queue and restores the register defaults; table
// contents are undefined until loaded.
module blade_section_interpolator #(
	parameter int MAX_SECTIONS = bsi_pkg::MAX_SECTIONS_DEF,
	parameter int FRAC_BITS = bsi_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [5:0]  section_index,
	input  logic [31:0] radius,
	input  logic [31:0] chord,
	input  logic [31:0] twist_deg,
	input  logic [31:0] sweep_deg,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] chord_out,
	output logic [31:0] twist_out,
	output logic [31:0] sweep_out,
	output logic        in_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import bsi_pkg::*;

	cfg_t  cfg_q;
	item_t q_item;
	logic  q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adimensional <= 1'b0;
			cfg_q.max_radius <= 32'd0;
			cfg_q.section_count <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ADIMENSIONAL: cfg_q.adimensional <= cfg_data[0];
				REG_MAX_RADIUS: cfg_q.max_radius <= cfg_data;
				REG_SECTION_COUNT: cfg_q.section_count <= cfg_data[6:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bsi_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.kind(kind), .section_index(section_index), .radius(radius),
		.chord(chord), .twist_deg(twist_deg), .sweep_deg(sweep_deg),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	bsi_back #(.MAX_SECTIONS(MAX_SECTIONS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.cfg(cfg_q),
		.result_valid(result_valid), .result_stall(result_stall),
		.chord_out(chord_out), .twist_out(twist_out), .sweep_out(sweep_out),
		.in_range(in_range)
	);

endmodule

>>> bench/tb_blade_section_interpolator.sv
// testbench for blade_section_interpolator: a directed table, then phases of random
// section loads and queries under changing register settings, all checked word by word
// against a behavioral predictor or fixed words; depends on bsi_pkg and block RTL
`timescale 1ns / 1ps

module tb_blade_section_interpolator;
	import bsi_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 400;
	localparam int PHASES = 12;
	localparam int QUERIES_PER_PHASE = 70;

	typedef struct packed {
		logic [31:0] chord;
		logic [31:0] twist;
		logic [31:0] sweep;
		logic        in_rng;
	} section_word_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  idx;
		logic [31:0] radius;
		logic [31:0] chord;
		logic [31:0] twist;
		logic [31:0] sweep;
		logic        typed;
		section_word_t want;
	} stim_row_t;

	logic clk, arst_n;
	logic item_valid, item_stall, kind;
	logic [5:0] section_index;
	logic [31:0] radius, chord, twist_deg, sweep_deg;
	logic result_valid, result_stall;
	logic [31:0] chord_out, twist_out, sweep_out;
	logic in_range;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	blade_section_interpolator dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .kind(kind),
		.section_index(section_index), .radius(radius), .chord(chord),
		.twist_deg(twist_deg), .sweep_deg(sweep_deg),
		.result_valid(result_valid), .result_stall(result_stall),
		.chord_out(chord_out), .twist_out(twist_out), .sweep_out(sweep_out),
		.in_range(in_range),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] sec_radius [64];
	logic [31:0] sec_chord [64];
	logic [31:0] sec_twist [64];
	logic [31:0] sec_sweep [64];
	logic        mode_adim;
	logic [31:0] tip_radius;
	logic [6:0]  count_reg;

	section_word_t pending_words[$];
	int mismatches = 0;
	int words_seen = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	bit quiet = 0;
	int stall_left = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] to_radians(logic [31:0] deg);
		longint d, mag, p;
		d = longint'($signed(deg));
		mag = (d < 0) ? -d : d;
		p = (mag * longint'(DEG_TO_RAD_Q32) + 64'sh80000000) >>> 32;
		return 32'((d < 0) ? -p : p);
	endfunction

	function automatic logic [31:0] blend(longint a, longint b, longint t);
		longint diff, mag, stp;
		diff = b - a;
		mag = (diff < 0) ? -diff : diff;
		stp = (mag * t + 64'sd32768) >>> 16;
		return 32'((diff < 0) ? a - stp : a + stp);
	endfunction

	function automatic section_word_t interpolate_at(logic [31:0] r_in);
		section_word_t w;
		longint r, q, span, t, rl, rh;
		int n, lo, hi;
		bit got_hi;
		r = longint'(r_in);
		if (mode_adim && tip_radius != 0) begin
			q = (r <<< 16) / longint'(tip_radius);
			r = (q > 64'sh0FFFFFFFF) ? 64'sh0FFFFFFFF : q;
		end
		n = (count_reg == 0) ? 1 : (count_reg > 64) ? 64 : int'(count_reg);
		w = '0;
		if (r < longint'(sec_radius[0]) || r > longint'(sec_radius[n-1]))
			return w;
		lo = 0; hi = 0; got_hi = 0;
		for (int i = 0; i < n; i++) begin
			if (longint'(sec_radius[i]) <= r)
				lo = i;
			if (!got_hi && longint'(sec_radius[i]) >= r) begin
				hi = i;
				got_hi = 1;
			end
		end
		rl = longint'(sec_radius[lo]);
		rh = longint'(sec_radius[hi]);
		span = rh - rl;
		if (span == 0)
			t = 0;
		else begin
			t = ((r - rl) <<< 16) / span;
			if (t > 65536)
				t = 65536;
		end
		w.chord = blend(longint'(sec_chord[lo]), longint'(sec_chord[hi]), t);
		w.twist = blend(longint'($signed(sec_twist[lo])), longint'($signed(sec_twist[hi])), t);
		w.sweep = blend(longint'($signed(sec_sweep[lo])), longint'($signed(sec_sweep[hi])), t);
		w.in_rng = 1'b1;
		return w;
	endfunction

	// drives one item, waits for acceptance, then updates the predictor
	task automatic send_item(logic k, logic [5:0] ix, logic [31:0] r, logic [31:0] c,
			logic [31:0] tw, logic [31:0] sw, bit typed, section_word_t want);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		section_index <= ix;
		radius <= r;
		chord <= c;
		twist_deg <= tw;
		sweep_deg <= sw;
		do @(posedge clk); while (item_stall);
		items_sent++;
		if (k == KIND_LOAD) begin
			sec_radius[ix] = r;
			sec_chord[ix] = c;
			sec_twist[ix] = to_radians(tw);
			sec_sweep[ix] = to_radians(sw);
		end else
			pending_words.push_back(typed ? want : interpolate_at(r));
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [1:0] ix, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= ix;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (ix)
			REG_ADIMENSIONAL: mode_adim = val[0];
			REG_MAX_RADIUS: tip_radius = val;
			REG_SECTION_COUNT: count_reg = val[6:0];
			default: ;
		endcase
	endtask

	// result side: per-word stall draw and comparison
	always @(posedge clk) begin
		section_word_t w;
		int draw;
		if (arst_n && result_valid && !result_stall) begin
			words_seen++;
			if (pending_words.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word chord=%h twist=%h sweep=%h in_range=%b",
					$time, chord_out, twist_out, sweep_out, in_range);
			end else begin
				w = pending_words.pop_front();
				if (w.chord !== chord_out || w.twist !== twist_out ||
						w.sweep !== sweep_out || w.in_rng !== in_range) begin
					mismatches++;
					$display("%0t: expected chord=%h twist=%h sweep=%h in_range=%b", $time,
						w.chord, w.twist, w.sweep, w.in_rng);
					$display("%0t: actual   chord=%h twist=%h sweep=%h in_range=%b", $time,
						chord_out, twist_out, sweep_out, in_range);
				end
			end
			draw = quiet ? 0 : $urandom_range(0, 13);
			stall_left <= draw;
			result_stall <= (draw != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_stall <= (stall_left > 1);
		end else
			result_stall <= 1'b0;
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog expired, %0d words outstanding", $time,
				pending_words.size());
			$display("tb: failure");
			$finish;
		end
	end

	// fills all entries; style 0 sorted, 1 sorted with repeated radii, 2 unsorted
	task automatic fill_table(int style, bit fractional);
		logic [31:0] r, stepmax;
		stepmax = fractional ? 32'd1000 : 32'h03000000;
		r = fractional ? $urandom_range(0, 200) : $urandom_range(0, 32'h01000000);
		for (int i = 0; i < 64; i++) begin
			send_item(KIND_LOAD, i[5:0], (style == 2) ? $urandom : r, $urandom, $urandom,
				$urandom, 0, '0);
			if (style == 1 && $urandom_range(0, 3) == 0)
				r = r;
			else
				r = r + $urandom_range(1, stepmax);
		end
	endtask

	function automatic logic [31:0] pick_query();
		int n, sel;
		longint lo_r, hi_r, target, scaled;
		n = (count_reg == 0) ? 1 : (count_reg > 64) ? 64 : int'(count_reg);
		lo_r = longint'(sec_radius[0]);
		hi_r = longint'(sec_radius[n-1]);
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom;
		if (sel == 1)
			target = lo_r - 1;
		else if (sel == 2)
			target = hi_r + 1;
		else if (sel == 3)
			target = longint'(sec_radius[$urandom_range(0, n - 1)]);
		else if (hi_r > lo_r)
			target = lo_r + longint'({$urandom, $urandom}) % (hi_r - lo_r + 1);
		else
			target = lo_r;
		if (target < 0)
			target = 0;
		if (mode_adim && tip_radius != 0) begin
			scaled = (target * longint'(tip_radius) + 64'sd65535) >>> 16;
			return (scaled > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF : scaled[31:0];
		end
		return target[31:0];
	endfunction

	stim_row_t directed [] = '{
		'{KIND_LOAD, 6'd0, 32'h00010000, 32'h00030000, 32'h0, 32'h0, 0, '0},
		'{KIND_QUERY, 6'd0, 32'h00010000, 0, 0, 0, 1, '{32'h00030000, 0, 0, 1'b1}},
		'{KIND_QUERY, 6'd0, 32'h00000000, 0, 0, 0, 1, '0},
		'{KIND_QUERY, 6'd0, 32'hFFFFFFFF, 0, 0, 0, 1, '0},
		'{KIND_LOAD, 6'd0, 32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0, '0},
		'{KIND_QUERY, 6'd0, 32'h0, 0, 0, 0, 0, '0},
		'{KIND_QUERY, 6'd0, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '0},
		'{KIND_LOAD, 6'd63, 32'hFFFFFFFF, 32'h0, 32'h80000000, 32'h7FFFFFFF, 0, '0},
		'{KIND_LOAD, 6'd1, 32'h00020000, 32'h0, 32'h005A0000, 32'hFFA60000, 0, '0},
		'{KIND_LOAD, 6'd0, 32'h00010000, 32'h00010000, 32'hFFD30000, 32'h002D0000, 0, '0},
		'{KIND_QUERY, 6'd0, 32'h00010000, 0, 0, 0, 0, '0},
		'{KIND_LOAD, 6'd0, 32'h00000000, 32'h0, 32'h0, 32'h0, 0, '0},
		'{KIND_QUERY, 6'd0, 32'h00000000, 0, 0, 0, 1, '{32'h0, 32'h0, 32'h0, 1'b1}}
	};

	initial begin
		int sc;
		logic [31:0] mr;
		arst_n = 1'b0;
		item_valid = 1'b0; kind = KIND_LOAD; section_index = '0;
		radius = '0; chord = '0; twist_deg = '0; sweep_deg = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0; cfg_index = REG_ADIMENSIONAL; cfg_data = '0;
		mode_adim = 1'b0; tip_radius = '0; count_reg = 7'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].kind, directed[i].idx, directed[i].radius,
				directed[i].chord, directed[i].twist, directed[i].sweep,
				directed[i].typed, directed[i].want);

		for (int p = 0; p < PHASES; p++) begin
			// sender holds off until every word is back before each register change
			wait_idle();
			quiet = (p == 5);
			case (p)
				0: sc = 64;
				1: sc = 1;
				2: sc = 0;
				3: sc = 127;
				default: sc = ($urandom_range(0, 4) == 0) ? $urandom_range(65, 127)
					: $urandom_range(1, 64);
			endcase
			case (p % 4)
				0: mr = 32'h0;
				1: mr = 32'hFFFFFFFF;
				2: mr = 32'h1;
				default: mr = $urandom_range(32'h00010000, 32'h01000000);
			endcase
			write_reg(REG_ADIMENSIONAL, {31'b0, (p % 3) != 0});
			write_reg(REG_MAX_RADIUS, mr);
			write_reg(REG_SECTION_COUNT, sc);
			cfg_valid <= 1'b0;
			if (p == 0 || p % 2 == 0 || p == 3)
				fill_table(p % 3, mode_adim && p % 4 == 3);
			for (int k = 0; k < QUERIES_PER_PHASE; k++) begin
				if ($urandom_range(0, 6) == 0)
					send_item(KIND_LOAD, 6'($urandom_range(0, 63)), $urandom, $urandom,
						$urandom, $urandom, 0, '0);
				else
					send_item(KIND_QUERY, 6'($urandom), pick_query(), $urandom, $urandom,
						$urandom, 0, '0);
			end
		end

		wait_idle();
		$display("covered %0d items and %0d result words over %0d register settings,",
			items_sent, words_seen, PHASES + 1);
		$display("including empty and saturated scaling, clamped counts and unsorted tables");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
